### rtl/gbfs_pkg.sv
// Shared types and constants for the breadth-first search level engine.
// Used by every module of the block; depends on nothing else.
package gbfs_pkg;

  localparam int VERTEX_W         = 4;
  localparam int LEVEL_W          = 4;
  localparam int NODE_COUNT_W     = 5;
  localparam int MAX_VERTICES_DEF = 16;
  localparam int MAX_RESULTS      = 16;
  localparam int COUNT_W          = $clog2(MAX_RESULTS);
  localparam int PADDR_W          = 3;
  localparam int PDATA_W          = 32;

  localparam logic [LEVEL_W-1:0]      LEVEL_MAX        = 4'd15;
  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 5'd16;

  // Operation codes of an input request.
  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_SEARCH   = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic                op;
    logic [VERTEX_W-1:0] first_node;
    logic [VERTEX_W-1:0] second_node;
  } in_item_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [LEVEL_W-1:0]  hop_level;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic                en;
    logic [VERTEX_W-1:0] node_a;
    logic [VERTEX_W-1:0] node_b;
  } edge_wr_t;

endpackage

### rtl/gbfs_cfg.sv
// APB-style configuration register holding node_count.
// Depends on gbfs_pkg.
module gbfs_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gbfs_pkg::PADDR_W-1:0]        paddr,
  input  logic [gbfs_pkg::PDATA_W-1:0]        pwdata,
  output logic [gbfs_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  output logic [gbfs_pkg::NODE_COUNT_W-1:0]   node_count
);
  import gbfs_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (wr_en && paddr[2] == REG_NODE_COUNT) begin
      node_count <= pwdata[NODE_COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_NODE_COUNT) ? PDATA_W'(node_count) : '0;

endmodule

### rtl/gbfs_graph.sv
// Adjacency bit matrix of the undirected graph, cleared at reset.
// Depends on gbfs_pkg; written by edge requests, read one row at a time.
module gbfs_graph #(
  parameter int MAX_VERTICES = gbfs_pkg::MAX_VERTICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  gbfs_pkg::edge_wr_t              edge_wr,
  input  logic [$clog2(MAX_VERTICES)-1:0] row_addr,
  output logic [MAX_VERTICES-1:0]         row_data
);
  import gbfs_pkg::*;

  localparam int IDXW = $clog2(MAX_VERTICES);

  logic [MAX_VERTICES-1:0] rows [MAX_VERTICES];
  logic                    in_range;
  logic [IDXW-1:0]         idx_a;
  logic [IDXW-1:0]         idx_b;

  // An edge with an endpoint outside the store is dropped.
  assign in_range = (int'(edge_wr.node_a) < MAX_VERTICES) &&
                    (int'(edge_wr.node_b) < MAX_VERTICES);
  assign idx_a    = IDXW'(edge_wr.node_a);
  assign idx_b    = IDXW'(edge_wr.node_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= '{default: '0};
    end else if (edge_wr.en && in_range) begin
      rows[idx_a][idx_b] <= 1'b1;
      rows[idx_b][idx_a] <= 1'b1;
    end
  end

  assign row_data = rows[row_addr];

endmodule

### rtl/gbfs_walk.sv
// Search sequencer: vertex queue, visited marks, level store, neighbour scan
// and result register. Depends on gbfs_pkg; reads rows from gbfs_graph.
module gbfs_walk #(
  parameter int MAX_VERTICES = gbfs_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [gbfs_pkg::NODE_COUNT_W-1:0] node_count,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  gbfs_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gbfs_pkg::out_item_t               out_data,
  output gbfs_pkg::edge_wr_t                edge_wr,
  output logic [$clog2(MAX_VERTICES)-1:0]   row_addr,
  input  logic [MAX_VERTICES-1:0]           row_data
);
  import gbfs_pkg::*;

  localparam int IDXW = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int NW   = (CNTW > NODE_COUNT_W) ? CNTW : NODE_COUNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]              state;
  logic [CNTW-1:0]         head;
  logic [CNTW-1:0]         tail;
  logic [IDXW-1:0]         scan_idx;
  logic [COUNT_W-1:0]      res_count;
  logic [MAX_VERTICES-1:0] visited;
  logic [LEVEL_W-1:0]      level_mem [MAX_VERTICES];
  logic [IDXW-1:0]         fifo_mem  [MAX_VERTICES];
  logic [IDXW-1:0]         cur_x;
  logic [LEVEL_W-1:0]      cur_lx;

  logic                    in_accept;
  logic                    start_ok;
  logic [IDXW-1:0]         start_idx;
  logic [NW-1:0]           nc_wide;
  logic [NW-1:0]           n_sat;
  logic                    hit;
  logic                    scan_done;
  logic [LEVEL_W-1:0]      lvl_inc;
  logic                    emit_last;
  logic                    out_free;
  logic [IDXW-1:0]         deq_x;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign start_ok  = int'(in_data.first_node) < MAX_VERTICES;
  assign start_idx = IDXW'(in_data.first_node);

  assign edge_wr.en     = in_accept && (in_data.op == OP_ADD_EDGE);
  assign edge_wr.node_a = in_data.first_node;
  assign edge_wr.node_b = in_data.second_node;

  // The scan range saturates at the size of the store.
  assign nc_wide = NW'(node_count);
  assign n_sat   = (nc_wide > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : nc_wide;

  assign row_addr  = cur_x;
  assign deq_x     = fifo_mem[head[IDXW-1:0]];
  assign hit       = row_data[scan_idx] && !visited[scan_idx] &&
                     (tail < CNTW'(MAX_VERTICES));
  assign scan_done = (NW'(scan_idx) + NW'(1)) == n_sat;
  assign lvl_inc   = (cur_lx == LEVEL_MAX) ? LEVEL_MAX : cur_lx + LEVEL_W'(1);

  // The queue is drained, or this is the final result the cap allows.
  assign emit_last = (head == tail) || (res_count == COUNT_W'(MAX_RESULTS - 1));
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      res_count <= '0;
      visited   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept && in_data.op == OP_SEARCH && start_ok) begin
            visited            <= MAX_VERTICES'(1) << start_idx;
            level_mem[start_idx] <= '0;
            fifo_mem[0]        <= start_idx;
            head               <= '0;
            tail               <= CNTW'(1);
            res_count          <= '0;
            state              <= S_DEQ;
          end
        end
        S_DEQ: begin
          cur_x    <= deq_x;
          cur_lx   <= level_mem[deq_x];
          head     <= head + CNTW'(1);
          scan_idx <= '0;
          state    <= (n_sat == '0) ? S_EMIT : S_SCAN;
        end
        S_SCAN: begin
          if (hit) begin
            visited[scan_idx]          <= 1'b1;
            level_mem[scan_idx]        <= lvl_inc;
            fifo_mem[tail[IDXW-1:0]]   <= scan_idx;
            tail                       <= tail + CNTW'(1);
          end
          if (scan_done) begin
            state <= S_EMIT;
          end else begin
            scan_idx <= scan_idx + IDXW'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_data.vertex    <= VERTEX_W'(cur_x);
            out_data.hop_level <= cur_lx;
            out_data.last      <= emit_last;
            res_count          <= res_count + COUNT_W'(1);
            state              <= emit_last ? S_IDLE : S_DEQ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/graph_bfs_level_engine_core.sv
// Breadth-first search engine over an adjacency bit matrix. An add-edge request
// is written into the matrix when accepted. A search request is accepted and then,
// for each of the R vertices it reaches (R at most 16), passes a dequeue step,
// a scan of n indices and a result step, where n is node_count limited to
// MAX_VERTICES; the result step waits while the result register is stalled.
// A single neighbour test and enqueue step is used once per scanned index.
// No new request is taken during a search; the final result may still wait
// in the output register.
// Depends on gbfs_pkg, gbfs_cfg, gbfs_graph and gbfs_walk.
module graph_bfs_level_engine_core #(
  parameter int MAX_VERTICES = gbfs_pkg::MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gbfs_pkg::PADDR_W-1:0] paddr,
  input  logic [gbfs_pkg::PDATA_W-1:0] pwdata,
  output logic [gbfs_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  gbfs_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output gbfs_pkg::out_item_t          out_data
);
  import gbfs_pkg::*;

  localparam int IDXW = $clog2(MAX_VERTICES);

  logic [NODE_COUNT_W-1:0] node_count;
  edge_wr_t                edge_wr;
  logic [IDXW-1:0]         row_addr;
  logic [MAX_VERTICES-1:0] row_data;

  gbfs_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .node_count (node_count)
  );

  gbfs_graph #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_graph (
    .clk      (clk),
    .rst      (rst),
    .edge_wr  (edge_wr),
    .row_addr (row_addr),
    .row_data (row_data)
  );

  gbfs_walk #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .node_count (node_count),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .edge_wr    (edge_wr),
    .row_addr   (row_addr),
    .row_data   (row_data)
  );

endmodule
